>>> rtl/core/rfpd_pkg.sv
package rfpd_pkg;

    localparam int ACCEL_W   = 20;
    localparam int ALT_W     = 24;
    localparam int TIME_W    = 32;
    localparam int MAG_W     = 20;
    localparam int MARGIN_W  = 23;
    localparam int LOCK_W    = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 23;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 40;

    localparam int SQ_W   = 40;
    localparam int ROOT_W = 41;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int WEIGHT_ONE   = 256;
    localparam int WEIGHT_BASE  = 179;
    localparam int WEIGHT_ALT   = 77;
    localparam int WEIGHT_MAG   = 205;

    localparam logic [TIME_W-1:0] BASE_WIN_LO = 32'd1000;
    localparam logic [TIME_W-1:0] BASE_WIN_HI = 32'd2000;

    localparam logic [MAG_W-1:0]    LAUNCH_ACCEL_RST  = 20'd30720;
    localparam logic [MAG_W-1:0]    LANDED_ACCEL_RST  = 20'd10035;
    localparam logic [MARGIN_W-1:0] LANDING_MARGIN_RST = 23'd1600;
    localparam logic [LOCK_W-1:0]   APOGEE_LOCK_RST   = 16'd2000;
    localparam logic [LOCK_W-1:0]   LANDING_LOCK_RST  = 16'd5000;
    localparam logic [LOCK_W-1:0]   COMPLETE_DELAY_RST = 16'd5000;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_ASCENT   = 3'd1,
        PH_DESCENT  = 3'd2,
        PH_LANDED   = 3'd3,
        PH_COMPLETE = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_LAUNCH   = 3'd1,
        EV_APOGEE   = 3'd2,
        EV_TOUCHDOWN = 3'd3,
        EV_COMPLETE = 3'd4
    } event_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LAUNCH_ACCEL   = 3'd0,
        CFG_LANDED_ACCEL   = 3'd1,
        CFG_LANDING_MARGIN = 3'd2,
        CFG_APOGEE_LOCK    = 3'd3,
        CFG_LANDING_LOCK   = 3'd4,
        CFG_COMPLETE_DELAY = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_SQUARE,
        FR_ROOT,
        FR_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FILTER,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic [MAG_W-1:0]        mag;
        logic signed [ALT_W-1:0] alt;
        logic [TIME_W-1:0]       stamp;
    } sample_t;

    typedef struct packed {
        logic [MAG_W-1:0]    launch_accel;
        logic [MAG_W-1:0]    landed_accel;
        logic [MARGIN_W-1:0] landing_margin;
        logic [LOCK_W-1:0]   apogee_lock;
        logic [LOCK_W-1:0]   landing_lock;
        logic [LOCK_W-1:0]   complete_delay;
    } cfg_t;

    typedef struct packed {
        logic [OUT_DATA_W-35:0]  pad;
        logic signed [ALT_W-1:0] peak_altitude;
        event_t                  event_code;
        logic                    landing_now;
        logic                    apogee_now;
        logic                    launch_now;
        logic                    in_flight;
        phase_t                  phase;
    } result_t;

    function automatic logic signed [ALT_W-1:0] blend_alt(
        input logic signed [ALT_W-1:0] prior,
        input logic signed [ALT_W-1:0] meas,
        input logic [8:0]              w
    );
        logic signed [33:0] wa;
        logic signed [33:0] wb;
        logic signed [33:0] sum;
        wa  = signed'(34'(w));
        wb  = signed'(34'(WEIGHT_ONE) - 34'(w));
        sum = wa * 34'(prior) + wb * 34'(meas);
        return sum[31:8];
    endfunction

endpackage

>>> rtl/core/rfpd_front.sv
module rfpd_front
    import rfpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    output logic                 push,
    input  logic                 full,
    output sample_t              push_data
);

    front_state_t             state_reg, state_next;
    logic [1:0]               idx_reg, idx_next;
    logic signed [ACCEL_W-1:0] ax_reg, ax_next;
    logic signed [ACCEL_W-1:0] ay_reg, ay_next;
    logic signed [ACCEL_W-1:0] az_reg, az_next;
    logic signed [ALT_W-1:0]  alt_reg, alt_next;
    logic [TIME_W-1:0]        stamp_reg, stamp_next;
    logic [SQ_W-1:0]          prod_reg, prod_next;
    logic [SQ_W-1:0]          rem_reg, rem_next;
    logic [ROOT_W-1:0]        res_reg, res_next;
    logic [ROOT_W-1:0]        bit_reg, bit_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        az_reg    <= az_next;
        alt_reg   <= alt_next;
        stamp_reg <= stamp_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        res_reg   <= res_next;
        bit_reg   <= bit_next;
    end

    always_comb begin
        logic signed [ACCEL_W-1:0] op;
        logic signed [SQ_W-1:0]    sq;
        logic [ROOT_W-1:0]         trial;
        state_next = state_reg;
        idx_next   = idx_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        az_next    = az_reg;
        alt_next   = alt_reg;
        stamp_next = stamp_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        push       = 1'b0;
        s_tready   = (state_reg == FR_IDLE);
        case (idx_reg)
            2'd0:    op = ax_reg;
            2'd1:    op = ay_reg;
            2'd2:    op = az_reg;
            default: op = '0;
        endcase
        sq    = op * op;
        trial = res_reg + bit_reg;
        case (state_reg)
            FR_IDLE: begin
                if (s_tvalid) begin
                    ax_next    = s_tdata[19:0];
                    ay_next    = s_tdata[39:20];
                    az_next    = s_tdata[59:40];
                    alt_next   = s_tdata[83:60];
                    stamp_next = s_tdata[115:84];
                    prod_next  = '0;
                    rem_next   = '0;
                    idx_next   = '0;
                    state_next = FR_SQUARE;
                end
            end
            FR_SQUARE: begin
                prod_next = unsigned'(sq);
                rem_next  = rem_reg + prod_reg;
                idx_next  = idx_reg + 2'd1;
                if (idx_reg == 2'd3) begin
                    res_next   = '0;
                    bit_next   = {1'b1, {(ROOT_W-1){1'b0}}};
                    state_next = FR_ROOT;
                end
            end
            FR_ROOT: begin
                if ({1'b0, rem_reg} >= trial) begin
                    rem_next = rem_reg - trial[SQ_W-1:0];
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == ROOT_W'(1)) begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH: begin
                if (!full) begin
                    push       = 1'b1;
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    assign push_data.mag   = res_reg[MAG_W-1:0];
    assign push_data.alt   = alt_reg;
    assign push_data.stamp = stamp_reg;

endmodule

>>> rtl/core/rfpd_queue.sv
module rfpd_queue
    import rfpd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  sample_t push_data,
    output logic    full,
    input  logic    pop,
    output sample_t pop_data,
    output logic    empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sample_t            entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

endmodule

>>> rtl/core/rfpd_back.sv
module rfpd_back
    import rfpd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  empty,
    output logic                  pop,
    input  sample_t               pop_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    back_state_t             state_reg, state_next;
    sample_t                 smp_reg, smp_next;
    logic signed [ALT_W-1:0] base_f_reg, base_f_next;
    logic signed [ALT_W-1:0] smooth_f_reg, smooth_f_next;
    logic [MAG_W-1:0]        mag_f_reg, mag_f_next;

    phase_t                  phase_reg, phase_next;
    logic signed [ALT_W-1:0] baseline_reg, baseline_next;
    logic signed [ALT_W-1:0] smooth_reg, smooth_next;
    logic signed [ALT_W-1:0] highest_reg, highest_next;
    logic [MAG_W-1:0]        smag_reg, smag_next;
    logic [TIME_W-1:0]       launch_t_reg, launch_t_next;
    logic [TIME_W-1:0]       apogee_t_reg, apogee_t_next;
    logic [TIME_W-1:0]       landed_t_reg, landed_t_next;

    logic                    out_valid_reg, out_valid_next;
    result_t                 out_reg, out_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            phase_reg     <= PH_IDLE;
            baseline_reg  <= '0;
            smooth_reg    <= '0;
            highest_reg   <= '0;
            smag_reg      <= '0;
            launch_t_reg  <= '0;
            apogee_t_reg  <= '0;
            landed_t_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            baseline_reg  <= baseline_next;
            smooth_reg    <= smooth_next;
            highest_reg   <= highest_next;
            smag_reg      <= smag_next;
            launch_t_reg  <= launch_t_next;
            apogee_t_reg  <= apogee_t_next;
            landed_t_reg  <= landed_t_next;
            out_valid_reg <= out_valid_next;
        end
        smp_reg      <= smp_next;
        base_f_reg   <= base_f_next;
        smooth_f_reg <= smooth_f_next;
        mag_f_reg    <= mag_f_next;
        out_reg      <= out_next;
    end

    always_comb begin
        logic [28:0]             mag_sum;
        logic signed [25:0]      alt_rel;
        logic                    in_window;
        logic                    go;
        phase_t                  ph;
        event_t                  ev;
        state_next     = state_reg;
        smp_next       = smp_reg;
        base_f_next    = base_f_reg;
        smooth_f_next  = smooth_f_reg;
        mag_f_next     = mag_f_reg;
        phase_next     = phase_reg;
        baseline_next  = baseline_reg;
        smooth_next    = smooth_reg;
        highest_next   = highest_reg;
        smag_next      = smag_reg;
        launch_t_next  = launch_t_reg;
        apogee_t_next  = apogee_t_reg;
        landed_t_next  = landed_t_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        pop            = 1'b0;
        ph             = phase_reg;
        ev             = EV_NONE;
        mag_sum = 29'(WEIGHT_MAG) * 29'(smag_reg)
                + 29'(WEIGHT_ONE - WEIGHT_MAG) * 29'(smp_reg.mag);
        alt_rel   = 26'(smp_reg.alt) - 26'(baseline_reg);
        in_window = (smp_reg.stamp > BASE_WIN_LO) && (smp_reg.stamp < BASE_WIN_HI);
        go        = !out_valid_reg || m_tready;
        case (state_reg)
            BK_IDLE: begin
                if (!empty) begin
                    pop        = 1'b1;
                    smp_next   = pop_data;
                    state_next = BK_FILTER;
                end
            end
            BK_FILTER: begin
                base_f_next   = blend_alt(baseline_reg, smp_reg.alt, 9'(WEIGHT_BASE));
                smooth_f_next = blend_alt(smooth_reg, smp_reg.alt, 9'(WEIGHT_ALT));
                mag_f_next    = mag_sum[27:8];
                state_next    = BK_EMIT;
            end
            BK_EMIT: begin
                if (go) begin
                    case (phase_reg)
                        PH_IDLE: begin
                            if (in_window) begin
                                baseline_next = base_f_reg;
                            end
                            if (smp_reg.mag > cfg.launch_accel) begin
                                ph            = PH_ASCENT;
                                launch_t_next = smp_reg.stamp;
                                ev            = EV_LAUNCH;
                            end
                        end
                        PH_ASCENT: begin
                            smooth_next = smooth_f_reg;
                            if ((smp_reg.stamp - launch_t_reg) > 32'(cfg.apogee_lock)
                                    && highest_reg > smooth_f_reg) begin
                                ph            = PH_DESCENT;
                                apogee_t_next = smp_reg.stamp;
                                ev            = EV_APOGEE;
                            end else if (smooth_f_reg > highest_reg) begin
                                highest_next = smooth_f_reg;
                            end
                        end
                        PH_DESCENT: begin
                            smag_next = mag_f_reg;
                            if (alt_rel < signed'(26'(cfg.landing_margin))
                                    && mag_f_reg < cfg.landed_accel
                                    && (smp_reg.stamp - apogee_t_reg)
                                        > 32'(cfg.landing_lock)) begin
                                ph            = PH_LANDED;
                                landed_t_next = smp_reg.stamp;
                                ev            = EV_TOUCHDOWN;
                            end
                        end
                        PH_LANDED: begin
                            if ((smp_reg.stamp - landed_t_reg) > 32'(cfg.complete_delay)) begin
                                ph = PH_COMPLETE;
                                ev = EV_COMPLETE;
                            end
                        end
                        default: ;
                    endcase
                    phase_next             = ph;
                    out_next.pad           = '0;
                    out_next.peak_altitude = highest_next;
                    out_next.event_code    = ev;
                    out_next.phase         = ph;
                    out_next.in_flight     = (ph == PH_ASCENT) || (ph == PH_DESCENT);
                    out_next.launch_now    = (phase_reg == PH_IDLE) && (ph == PH_ASCENT);
                    out_next.apogee_now    = (phase_reg == PH_ASCENT) && (ph == PH_DESCENT);
                    out_next.landing_now   = (phase_reg != PH_LANDED) && (ph == PH_LANDED);
                    out_valid_next         = 1'b1;
                    state_next             = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

>>> rtl/core/rocket_flight_phase_detector_top.sv
// path: front squares, roots and queues each word; back pops, filters and registers it
// flow: the front takes one word at a time and holds s_tready low through the square
// accumulation, the 21-step shift-and-subtract square root and the push into the queue
// stalls: with m_tready held low, five words are taken before s_tready stays low
// reset: aresetn is synchronous, active low; phase goes to idle, flight state and
// event times to zero, thresholds and lockouts to their default values
module rocket_flight_phase_detector_top
    import rfpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // accel_x, accel_y, accel_z, altitude, sample_time_ms, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // phase, in_flight, launch_now, apogee_now, landing_now, event_code,
    // peak_altitude, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    cfg_t    cfg_reg, cfg_next;
    logic    q_push, q_full, q_pop, q_empty;
    sample_t q_in, q_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.launch_accel   <= LAUNCH_ACCEL_RST;
            cfg_reg.landed_accel   <= LANDED_ACCEL_RST;
            cfg_reg.landing_margin <= LANDING_MARGIN_RST;
            cfg_reg.apogee_lock    <= APOGEE_LOCK_RST;
            cfg_reg.landing_lock   <= LANDING_LOCK_RST;
            cfg_reg.complete_delay <= COMPLETE_DELAY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index_t'(cfg_addr))
                CFG_LAUNCH_ACCEL:   cfg_next.launch_accel   = cfg_wdata[MAG_W-1:0];
                CFG_LANDED_ACCEL:   cfg_next.landed_accel   = cfg_wdata[MAG_W-1:0];
                CFG_LANDING_MARGIN: cfg_next.landing_margin = cfg_wdata[MARGIN_W-1:0];
                CFG_APOGEE_LOCK:    cfg_next.apogee_lock    = cfg_wdata[LOCK_W-1:0];
                CFG_LANDING_LOCK:   cfg_next.landing_lock   = cfg_wdata[LOCK_W-1:0];
                CFG_COMPLETE_DELAY: cfg_next.complete_delay = cfg_wdata[LOCK_W-1:0];
                default: ;
            endcase
        end
    end

    rfpd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (q_push),
        .full      (q_full),
        .push_data (q_in)
    );

    rfpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    rfpd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .empty    (q_empty),
        .pop      (q_pop),
        .pop_data (q_out),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    assert property (@(posedge aclk) disable iff (!aresetn) !(q_push && q_full))
        else $error("push into full queue");

    assert property (@(posedge aclk) disable iff (!aresetn) !(q_pop && q_empty))
        else $error("pop from empty queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("front took a second word while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[4]) |-> (m_tdata[2:0] == PH_ASCENT && m_tdata[9:7] == EV_LAUNCH))
        else $error("launch flag without ascent phase and launch event");

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rfpd_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int W_BASELINE = 179;
    localparam int W_ALTITUDE = 77;
    localparam int W_ACCEL    = 205;
    localparam int W_FULL     = 256;
    localparam logic [TIME_W-1:0] WINDOW_OPEN  = 32'd1000;
    localparam logic [TIME_W-1:0] WINDOW_CLOSE = 32'd2000;
    localparam result_t RES_GROUND = '0;

    typedef struct packed {
        logic [3:0]               pad;
        logic [TIME_W-1:0]        stamp;
        logic signed [ALT_W-1:0]  altitude;
        logic signed [ACCEL_W-1:0] accel_z;
        logic signed [ACCEL_W-1:0] accel_y;
        logic signed [ACCEL_W-1:0] accel_x;
    } sensor_word_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_ADDR_W-1:0]     idx;
        logic [CFG_DATA_W-1:0]     val;
        logic [ACCEL_W-1:0]        ax;
        logic [ACCEL_W-1:0]        ay;
        logic [ACCEL_W-1:0]        az;
        logic [ALT_W-1:0]          alt;
        logic [TIME_W-1:0]         stamp;
        logic                      typed;
        result_t                   want;
    } script_row_t;

    typedef enum logic [2:0] {ST_GROUND, ST_CLIMB, ST_FALL, ST_TOUCH, ST_REST} stage_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // accel_x, accel_y, accel_z, altitude, sample_time_ms, zero pad
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // phase, in_flight, launch_now, apogee_now, landing_now, event_code,
    // peak_altitude, zero pad
    logic [OUT_DATA_W-1:0] m_tdata;

    rocket_flight_phase_detector_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // flight state mirror
    logic [MAG_W-1:0]        lim_launch;
    logic [MAG_W-1:0]        lim_quiet;
    logic [MARGIN_W-1:0]     alt_margin;
    logic [LOCK_W-1:0]       lock_apogee;
    logic [LOCK_W-1:0]       lock_landing;
    logic [LOCK_W-1:0]       delay_complete;
    phase_t                  cur_phase;
    logic signed [ALT_W-1:0] base_alt;
    logic signed [ALT_W-1:0] smooth_alt;
    logic signed [ALT_W-1:0] peak_alt;
    logic [MAG_W-1:0]        smooth_mag;
    logic [TIME_W-1:0]       t_launch;
    logic [TIME_W-1:0]       t_apogee;
    logic [TIME_W-1:0]       t_landed;

    result_t awaited_reports [$];
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req = 1'b0;
    int n_sent   = 0;
    int n_checked = 0;
    int n_writes = 0;
    int n_err    = 0;
    int n_events [5] = '{0, 0, 0, 0, 0};

    logic [TIME_W-1:0]       clock_ms;
    logic signed [ALT_W-1:0] track_alt;

    script_row_t ground_script [13] = '{
        '{ROW_SAMPLE, CFG_LAUNCH_ACCEL, 23'd0, 20'd0, 20'd0, 20'd0,
          24'd0, 32'd0, 1'b1, RES_GROUND},
        '{ROW_SAMPLE, CFG_LAUNCH_ACCEL, 23'd0, 20'd1000, 20'hFFC18, 20'd500,
          24'h7FFFFF, 32'd1001, 1'b0, RES_GROUND},
        '{ROW_SAMPLE, CFG_LAUNCH_ACCEL, 23'd0, 20'd0, 20'd0, 20'hFF830,
          24'h800000, 32'd1999, 1'b0, RES_GROUND},
        '{ROW_SAMPLE, CFG_LAUNCH_ACCEL, 23'd0, 20'd3, 20'd4, 20'd0,
          24'd123456, 32'd1000, 1'b0, RES_GROUND},
        '{ROW_SAMPLE, CFG_LAUNCH_ACCEL, 23'd0, 20'd0, 20'd0, 20'd0,
          24'hFFFFFB, 32'd2000, 1'b0, RES_GROUND},
        '{ROW_SAMPLE, CFG_LAUNCH_ACCEL, 23'd0, 20'd30720, 20'd0, 20'd0,
          24'd0, 32'd1500, 1'b1, RES_GROUND},
        '{ROW_WRITE, CFG_LAUNCH_ACCEL, 23'h7FFFFF, 20'd0, 20'd0, 20'd0,
          24'd0, 32'd0, 1'b0, RES_GROUND},
        '{ROW_WRITE, CFG_SPARE_LO, 23'h5A5A5A, 20'd0, 20'd0, 20'd0,
          24'd0, 32'd0, 1'b0, RES_GROUND},
        '{ROW_WRITE, CFG_SPARE_HI, 23'h000001, 20'd0, 20'd0, 20'd0,
          24'd0, 32'd0, 1'b0, RES_GROUND},
        '{ROW_SAMPLE, CFG_LAUNCH_ACCEL, 23'd0, 20'h80000, 20'h80000, 20'h80000,
          24'h800000, 32'hFFFFFFFF, 1'b1, RES_GROUND},
        '{ROW_SAMPLE, CFG_LAUNCH_ACCEL, 23'd0, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF,
          24'h7FFFFF, 32'd1500, 1'b1, RES_GROUND},
        '{ROW_SAMPLE, CFG_LAUNCH_ACCEL, 23'd0, 20'h80000, 20'h7FFFF, 20'd0,
          24'd0, 32'd1200, 1'b0, RES_GROUND},
        '{ROW_SAMPLE, CFG_LAUNCH_ACCEL, 23'd0, 20'd0, 20'd0, 20'd1,
          24'd1, 32'd1001, 1'b0, RES_GROUND}
    };

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void ground_reset();
        lim_launch     = LAUNCH_ACCEL_RST;
        lim_quiet      = LANDED_ACCEL_RST;
        alt_margin     = LANDING_MARGIN_RST;
        lock_apogee    = APOGEE_LOCK_RST;
        lock_landing   = LANDING_LOCK_RST;
        delay_complete = COMPLETE_DELAY_RST;
        cur_phase      = PH_IDLE;
        base_alt       = '0;
        smooth_alt     = '0;
        peak_alt       = '0;
        smooth_mag     = '0;
        t_launch       = '0;
        t_apogee       = '0;
        t_landed       = '0;
    endfunction

    function automatic logic [MAG_W-1:0] int_sqrt(input longint v);
        logic [MAG_W-1:0] root;
        longint trial;
        root = '0;
        for (int b = MAG_W - 1; b >= 0; b--) begin
            root[b] = 1'b1;
            trial = longint'(root);
            if (trial * trial > v) root[b] = 1'b0;
        end
        return root;
    endfunction

    function automatic logic signed [ALT_W-1:0] mix_alt(
        input logic signed [ALT_W-1:0] prior,
        input logic signed [ALT_W-1:0] meas,
        input int w
    );
        longint acc;
        acc = longint'(w) * longint'(prior) + longint'(W_FULL - w) * longint'(meas);
        return ALT_W'(acc >>> 8);
    endfunction

    function automatic logic signed [ALT_W-1:0] clamp_alt(input longint v);
        if (v > 64'sd8388607) return 24'sh7FFFFF;
        if (v < -64'sd8388608) return 24'sh800000;
        return ALT_W'(v);
    endfunction

    function automatic result_t predict_flight(input sensor_word_t w);
        phase_t                  prev;
        event_t                  ev;
        longint                  gx, gy, gz;
        logic [MAG_W-1:0]        mag;
        logic signed [ALT_W-1:0] alt;
        logic [TIME_W-1:0]       span;
        result_t                 res;
        gx   = longint'(signed'(w.accel_x));
        gy   = longint'(signed'(w.accel_y));
        gz   = longint'(signed'(w.accel_z));
        mag  = int_sqrt(gx * gx + gy * gy + gz * gz);
        alt  = signed'(w.altitude);
        prev = cur_phase;
        ev   = EV_NONE;
        case (cur_phase)
            PH_IDLE: begin
                if (w.stamp > WINDOW_OPEN && w.stamp < WINDOW_CLOSE)
                    base_alt = mix_alt(base_alt, alt, W_BASELINE);
                if (mag > lim_launch) begin
                    cur_phase = PH_ASCENT;
                    t_launch  = w.stamp;
                    ev        = EV_LAUNCH;
                end
            end
            PH_ASCENT: begin
                smooth_alt = mix_alt(smooth_alt, alt, W_ALTITUDE);
                span = w.stamp - t_launch;
                if (span > TIME_W'(lock_apogee) && peak_alt > smooth_alt) begin
                    cur_phase = PH_DESCENT;
                    t_apogee  = w.stamp;
                    ev        = EV_APOGEE;
                end else if (smooth_alt > peak_alt) begin
                    peak_alt = smooth_alt;
                end
            end
            PH_DESCENT: begin
                smooth_mag = MAG_W'((longint'(W_ACCEL) * longint'(smooth_mag) +
                                     longint'(W_FULL - W_ACCEL) * longint'(mag)) >> 8);
                span = w.stamp - t_apogee;
                if (longint'(alt) - longint'(base_alt) < longint'(alt_margin) &&
                    smooth_mag < lim_quiet && span > TIME_W'(lock_landing)) begin
                    cur_phase = PH_LANDED;
                    t_landed  = w.stamp;
                    ev        = EV_TOUCHDOWN;
                end
            end
            PH_LANDED: begin
                span = w.stamp - t_landed;
                if (span > TIME_W'(delay_complete)) begin
                    cur_phase = PH_COMPLETE;
                    ev        = EV_COMPLETE;
                end
            end
            default: ;
        endcase
        res               = '0;
        res.phase         = cur_phase;
        res.in_flight     = (cur_phase == PH_ASCENT || cur_phase == PH_DESCENT);
        res.launch_now    = (prev == PH_IDLE && cur_phase == PH_ASCENT);
        res.apogee_now    = (prev == PH_ASCENT && cur_phase == PH_DESCENT);
        res.landing_now   = (prev != PH_LANDED && cur_phase == PH_LANDED);
        res.event_code    = ev;
        res.peak_altitude = peak_alt;
        return res;
    endfunction

    function automatic int field_diff(input string tag, input longint want, input longint got);
        if (want == got) return 0;
        $display("%0t: %s expected %0d got %0d", $time, tag, want, got);
        return 1;
    endfunction

    task automatic check_report(input logic [OUT_DATA_W-1:0] word);
        result_t got;
        result_t want;
        got = result_t'(word);
        if (awaited_reports.size() == 0) begin
            $display("%0t: result word with nothing expected, got %h", $time, word);
            n_err++;
        end else begin
            want = awaited_reports.pop_front();
            n_err += field_diff("phase", want.phase, got.phase);
            n_err += field_diff("in_flight", want.in_flight, got.in_flight);
            n_err += field_diff("launch_now", want.launch_now, got.launch_now);
            n_err += field_diff("apogee_now", want.apogee_now, got.apogee_now);
            n_err += field_diff("landing_now", want.landing_now, got.landing_now);
            n_err += field_diff("event_code", want.event_code, got.event_code);
            n_err += field_diff("peak_altitude", want.peak_altitude, got.peak_altitude);
            if (got.event_code <= EV_COMPLETE) n_events[got.event_code]++;
            n_checked++;
        end
    endtask

    // receiver: random ready, with a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
            @(posedge aclk);
            if (m_tvalid && m_tready) check_report(m_tdata);
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_LAUNCH_ACCEL:   lim_launch     = val[MAG_W-1:0];
            CFG_LANDED_ACCEL:   lim_quiet      = val[MAG_W-1:0];
            CFG_LANDING_MARGIN: alt_margin     = val[MARGIN_W-1:0];
            CFG_APOGEE_LOCK:    lock_apogee    = val[LOCK_W-1:0];
            CFG_LANDING_LOCK:   lock_landing   = val[LOCK_W-1:0];
            CFG_COMPLETE_DELAY: delay_complete = val[LOCK_W-1:0];
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic send_item(input sensor_word_t w, input logic typed, input result_t want);
        result_t guess;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        guess = predict_flight(w);
        awaited_reports.push_back(typed ? want : guess);
        n_sent++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [ACCEL_W-1:0] rand_accel();
        case ($urandom_range(0, 7))
            0: return 20'h80000;
            1: return 20'h7FFFF;
            2: return '0;
            3, 4, 5: return ACCEL_W'($urandom_range(0, 80000) - 40000);
            default: return ACCEL_W'($urandom);
        endcase
    endfunction

    task automatic run_flight_stage(input stage_t st, input int count);
        sensor_word_t w;
        longint off;
        for (int i = 0; i < count; i++) begin
            w = '0;
            w.accel_x = rand_accel();
            w.accel_y = rand_accel();
            w.accel_z = rand_accel();
            case (st)
                ST_GROUND: begin
                    w.altitude = ALT_W'($urandom);
                    w.stamp = ($urandom_range(0, 1) == 1) ? TIME_W'($urandom_range(990, 2010))
                                                          : TIME_W'($urandom);
                end
                ST_CLIMB: begin
                    clock_ms += $urandom_range(1, 20);
                    off = longint'($urandom_range(0, 450)) - 50;
                    track_alt = clamp_alt(longint'(track_alt) + off);
                    w.altitude = track_alt;
                    w.stamp = clock_ms;
                end
                ST_FALL: begin
                    clock_ms += $urandom_range(1, 50);
                    off = -longint'($urandom_range(0, 300));
                    if ($urandom_range(0, 9) == 0) off += 600;
                    track_alt = clamp_alt(longint'(track_alt) + off);
                    w.altitude = track_alt;
                    w.stamp = clock_ms;
                end
                ST_TOUCH: begin
                    clock_ms += $urandom_range(200, 2000);
                    off = longint'($urandom_range(0, 4500 + alt_margin)) - 3000;
                    w.altitude = clamp_alt(longint'(base_alt) + off);
                    w.stamp = clock_ms;
                end
                default: begin
                    clock_ms += $urandom_range(1, 100);
                    w.altitude = ALT_W'($urandom);
                    w.stamp = clock_ms;
                end
            endcase
            send_item(w, 1'b0, RES_GROUND);
        end
    endtask

    initial begin
        sensor_word_t w;
        ground_reset();
        send_idle_pct = 28;
        recv_idle_pct = 84;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (ground_script[i]) begin
            if (ground_script[i].kind == ROW_WRITE) begin
                wait_drain();
                write_reg(ground_script[i].idx, ground_script[i].val);
            end else begin
                w = '0;
                w.accel_x  = ground_script[i].ax;
                w.accel_y  = ground_script[i].ay;
                w.accel_z  = ground_script[i].az;
                w.altitude = ground_script[i].alt;
                w.stamp    = ground_script[i].stamp;
                send_item(w, ground_script[i].typed, ground_script[i].want);
            end
        end

        // on the pad, launch impossible
        run_flight_stage(ST_GROUND, 150);

        // launch on first motion, apogee locked out for the climb
        wait_drain();
        write_reg(CFG_LAUNCH_ACCEL, '0);
        write_reg(CFG_APOGEE_LOCK, 23'h00FFFF);
        send_idle_pct = 84;
        recv_idle_pct = 28;
        clock_ms  = 32'hFFFF_FC00;
        track_alt = '0;
        run_flight_stage(ST_CLIMB, 120);

        // apogee on the first drop, landing impossible
        wait_drain();
        write_reg(CFG_APOGEE_LOCK, '0);
        write_reg(CFG_LANDED_ACCEL, '0);
        write_reg(CFG_LANDING_MARGIN, 23'h7FFFFF);
        write_reg(CFG_LANDING_LOCK, '0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        run_flight_stage(ST_FALL, 100);

        // touchdown after a long lockout, completion held off
        wait_drain();
        write_reg(CFG_LANDED_ACCEL, 23'h7FFFFF);
        write_reg(CFG_LANDING_MARGIN, CFG_DATA_W'($urandom_range(100, 5000)));
        write_reg(CFG_LANDING_LOCK, 23'h00FFFF);
        write_reg(CFG_COMPLETE_DELAY, 23'h00FFFF);
        run_flight_stage(ST_TOUCH, 100);

        wait_drain();
        write_reg(CFG_COMPLETE_DELAY, '0);
        run_flight_stage(ST_REST, 40);
        wait_drain();

        $display("%0d samples sent, %0d result words checked, %0d register writes",
                 n_sent, n_checked, n_writes);
        $display("events seen: launch %0d apogee %0d touchdown %0d complete %0d, final phase %s",
                 n_events[EV_LAUNCH], n_events[EV_APOGEE], n_events[EV_TOUCHDOWN],
                 n_events[EV_COMPLETE], cur_phase.name());
        if (n_err == 0 && awaited_reports.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d result words outstanding", awaited_reports.size());
        $display("FAILURE");
        $finish;
    end

endmodule
